### src/keyboard_scan_code_filter_unit_macros.svh
// Assertion macros used by the keyboard scan code filter RTL.
`ifndef KEYBOARD_SCAN_CODE_FILTER_UNIT_MACROS_SVH
`define KEYBOARD_SCAN_CODE_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define KSCF_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("kscf assertion failed");
`define KSCF_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("kscf assertion failed");
`else
`define KSCF_ASSERT_NOW(lbl, ck, rs, ante, cons)
`define KSCF_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

### src/kscf_pkg.sv
// Types, codes and the mode rewrite table of the keyboard scan code filter.
package kscf_pkg;

  localparam logic [15:0] CODE_INSERT     = 16'h0052;
  localparam logic [15:0] CODE_END_KEYPAD = 16'h0050;
  localparam logic [15:0] CODE_CTRL       = 16'h001d;
  localparam logic [15:0] CODE_ALT        = 16'h0038;
  localparam logic [15:0] CODE_END        = 16'h004f;
  localparam logic [15:0] CODE_LSHIFT     = 16'h002a;
  localparam logic [15:0] CODE_SEQ_FIRST  = 16'h0002;
  localparam logic [15:0] CODE_SEQ_MID    = 16'h0004;
  localparam logic [15:0] CODE_SEQ_LAST   = 16'h0008;

  localparam logic [2:0] FLAGS_MAKE  = 3'd0;
  localparam logic [2:0] FLAGS_BREAK = 3'd1;

  localparam logic [1:0] SEQ_LAST_SLOT = 2'd3;

  typedef enum logic [1:0] {
    PART_NONE = 2'd0,
    PART_4F   = 2'd1,
    PART_2A   = 2'd2
  } end_part_t;

  typedef struct packed {
    logic             ctrl_held;
    logic             alt_held;
    logic             end_held;
    logic             end_via_shift_prefix;
    end_part_t        last_end_part;
    logic [3:0][15:0] release_sequence;
    logic [1:0]       sequence_count;
    logic             remap_mode;
  } kscf_state_t;

  localparam kscf_state_t STATE_RESET = '{
    ctrl_held: 1'b0,
    alt_held: 1'b0,
    end_held: 1'b0,
    end_via_shift_prefix: 1'b0,
    last_end_part: PART_NONE,
    release_sequence: '0,
    sequence_count: 2'd0,
    remap_mode: 1'b0
  };

  function automatic logic [15:0] mode_rewrite(input logic [15:0] c);
    logic [15:0] r;
    case (c)
      16'h001e: r = 16'h0005;
      16'h0012: r = 16'h0004;
      16'h0022: r = 16'h000a;
      16'h0026: r = 16'h0002;
      16'h0018: r = 16'h000b;
      16'h001f: r = 16'h0006;
      default:  r = c;
    endcase
    return r;
  endfunction

endpackage

### src/kscf_event.sv
// Next-state and result logic for one keyboard event.
module kscf_event (
  input  logic [15:0]         make_code,
  input  logic [2:0]          key_flags,
  input  kscf_pkg::kscf_state_t st,
  output kscf_pkg::kscf_state_t st_next,
  output logic [15:0]         out_code
);
  import kscf_pkg::*;

  logic [15:0] code;
  logic        is_make;
  logic        is_break;
  logic        seq_match;

  assign is_make  = (key_flags == FLAGS_MAKE);
  assign is_break = (key_flags == FLAGS_BREAK);
  assign code     = (make_code == CODE_INSERT) ? CODE_END_KEYPAD : make_code;

  assign seq_match = (st.release_sequence[0] == CODE_SEQ_FIRST) &&
                     (st.release_sequence[1] == CODE_SEQ_MID) &&
                     (st.release_sequence[2] == CODE_SEQ_MID) &&
                     (code == CODE_SEQ_LAST);

  always_comb begin
    st_next = st;
    if (code == CODE_CTRL || code == CODE_ALT) begin
      if (code == CODE_CTRL) begin
        if (is_make) st_next.ctrl_held = 1'b1;
        else if (is_break) st_next.ctrl_held = 1'b0;
      end else begin
        if (is_make) st_next.alt_held = 1'b1;
        else if (is_break) st_next.alt_held = 1'b0;
      end
      if (!st.end_via_shift_prefix) begin
        st_next.last_end_part = PART_NONE;
        st_next.end_held = 1'b0;
      end
    end else if (code == CODE_LSHIFT) begin
      case (st.last_end_part)
        PART_NONE: begin
          st_next.end_via_shift_prefix = 1'b1;
          st_next.end_held = 1'b1;
        end
        PART_4F: begin
          st_next.end_via_shift_prefix = 1'b0;
          st_next.end_held = 1'b0;
        end
        default: ;
      endcase
      st_next.last_end_part = PART_2A;
    end else if (code == CODE_END) begin
      if (st.end_via_shift_prefix) begin
        if (st.last_end_part == PART_2A) st_next.end_held = 1'b1;
      end else begin
        if (st.last_end_part == PART_NONE) st_next.end_held = 1'b1;
      end
      st_next.last_end_part = PART_4F;
    end else if (code == CODE_SEQ_FIRST && is_break) begin
      st_next.sequence_count = 2'd0;
      st_next.release_sequence = '0;
      if (!st.end_via_shift_prefix) begin
        st_next.last_end_part = PART_NONE;
        st_next.end_held = 1'b0;
      end
    end else begin
      st_next.ctrl_held = 1'b0;
      st_next.alt_held = 1'b0;
      st_next.end_held = 1'b0;
      if (!st.end_via_shift_prefix) st_next.last_end_part = PART_NONE;
    end

    if (is_break) begin
      st_next.release_sequence[st_next.sequence_count] = code;
      if (st_next.sequence_count == SEQ_LAST_SLOT) begin
        if (seq_match) st_next.remap_mode = !st.remap_mode;
        st_next.sequence_count = 2'd0;
        st_next.release_sequence = '0;
      end else begin
        st_next.sequence_count = st_next.sequence_count + 2'd1;
      end
    end

    out_code = st_next.remap_mode ? mode_rewrite(code) : code;
  end

endmodule

### src/keyboard_scan_code_filter_unit.sv
// Top level of the keyboard scan code filter: input stage, state and result register.
// It takes one event per cycle while in_stall is low; each event gives one result.
// An accepted request sits in an input register; in the next cycle in which the result
// register is free or being taken, it passes through one level of compare logic, updates
// the held-key, sequence and remap state, and lands in the result register, so its result
// is valid from the clock edge after the one that accepts the request, at the earliest.
// A request is taken while a result still waits, as long as the input register is free.
`include "keyboard_scan_code_filter_unit_macros.svh"

module keyboard_scan_code_filter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] make_code,
  input  logic [2:0]  key_flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code,
  output logic        reset_request,
  output logic        remap_active
);
  import kscf_pkg::*;

  logic        in_full;
  logic [15:0] in_code;
  logic [2:0]  in_flags;
  kscf_state_t st;
  kscf_state_t st_next;
  logic [15:0] code_next;
  logic        advance;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  kscf_event u_event (
    .make_code (in_code),
    .key_flags (in_flags),
    .st        (st),
    .st_next   (st_next),
    .out_code  (code_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      st        <= STATE_RESET;
    end else begin
      if (in_valid && !in_stall) begin
        in_full  <= 1'b1;
        in_code  <= make_code;
        in_flags <= key_flags;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid     <= 1'b1;
        out_code      <= code_next;
        reset_request <= st_next.ctrl_held && st_next.alt_held && st_next.end_held;
        remap_active  <= st_next.remap_mode;
        st            <= st_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `KSCF_ASSERT_NEXT(a_result_matches_state, clk, rst, advance,
    (reset_request == (st.ctrl_held && st.alt_held && st.end_held)) &&
    (remap_active == st.remap_mode))
  `KSCF_ASSERT_NOW(a_empty_sequence_cleared, clk, rst, st.sequence_count == 2'd0,
    st.release_sequence == '0)
  `KSCF_ASSERT_NEXT(a_mode_toggles_on_release_only, clk, rst,
    !(advance && in_flags == FLAGS_BREAK), $stable(st.remap_mode))

endmodule
